@@ hdl/lkvc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key-value cache core.
// ---------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lkvc_state_t;

  typedef struct packed {
    logic capture;
    logic shift;
  } lkvc_cell_ctl_t;

endpackage

@@ hdl/lkvc_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lkvc_cell
// One recency slot: holds a key/value pair, flags a key match, and takes
// its neighbor's entry when the chain shifts.
// ---------------------------------------------------------------------------
module lkvc_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lkvc_pkg::lkvc_cell_ctl_t     ctl,
  input  logic [lkvc_pkg::KEY_W-1:0]   cmp_key,
  input  logic [lkvc_pkg::KEY_W-1:0]   prev_key,
  input  logic [lkvc_pkg::VAL_W-1:0]   prev_val,
  input  logic                         prev_valid,
  input  logic                         seen_in,
  output logic [lkvc_pkg::KEY_W-1:0]   key,
  output logic [lkvc_pkg::VAL_W-1:0]   val,
  output logic                         valid,
  output logic                         match,
  output logic                         seen_out
);
  import lkvc_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic             valid_r;
  logic             match_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r <= prev_key;
      val_r <= prev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.shift) begin
        valid_r <= prev_valid;
      end
      if (ctl.capture) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
    end
  end

  assign key      = key_r;
  assign val      = val_r;
  assign valid    = valid_r;
  assign match    = match_r;
  assign seen_out = seen_in | match_r;

endmodule

@@ hdl/lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key-value cache with least-recently-used replacement.
// ---------------------------------------------------------------------------
// Input stream: in_tuser is the operation (0 get, 1 put), in_tdata carries
// key and value. A get yields one output transfer: out_tuser is the hit flag,
// out_tdata the stored value on a hit or all ones on a miss. A put yields
// nothing. Entries sit in a row of cells ordered by recency, cell 0 the most
// recent; a hit or an insert moves the entry to cell 0 while the cells in
// front of it shift one place back, and an insert into a full cache drops
// the last valid cell.
// The transfer cycle compares the key against every cell and registers the
// match flags; the update state then shifts the chain and, for a get, loads
// the output register; no new item is taken before then. If a get result
// waits in the output register, the update holds until taken; puts proceed.
// cfg_wr_data sets the capacity (0 acts as 1, above ENTRIES acts as ENTRIES);
// write it only while idle. Reset empties the cache and sets capacity to 16.
// ---------------------------------------------------------------------------
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // key[31:0], value[63:32]
  input  logic                        in_tuser,   // op
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // read_value[31:0]
  output logic                        out_tuser,  // hit
  input  logic                        cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_wr_data // capacity
);
  import lkvc_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  lkvc_state_t      state_r, state_nxt;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r;
  logic [VAL_W-1:0] out_val_r;

  logic             accept;
  logic             apply;
  logic             out_load;

  logic [KEY_W-1:0] cell_key   [ENTRIES];
  logic [VAL_W-1:0] cell_val   [ENTRIES];
  logic [ENTRIES-1:0] cell_valid;
  logic [ENTRIES-1:0] cell_match;
  logic [ENTRIES:0]   seen;

  logic             hit_any;
  logic [VAL_W-1:0] hit_val;
  logic [VAL_W-1:0] head_val;
  logic [LW-1:0]    lim;
  logic             full;
  logic [CNT_W-1:0] top;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_UPDATE;
      ST_UPDATE: if (apply)  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    apply     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_UPDATE: begin
        apply    = (op_r == OP_PUT) || !out_valid_r || out_tready;
        out_load = apply && (op_r == OP_GET);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[31:0];
      val_r <= in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val = hit_val | (cell_val[i] & {VAL_W{cell_match[i]}});
    end
  end

  assign hit_any  = seen[ENTRIES];
  assign head_val = (op_r == OP_PUT) ? val_r : hit_val;

  always_comb begin
    if (cap_r == '0) begin
      lim = LW'(1);
    end else if (LW'(cap_r) > LW'(ENTRIES)) begin
      lim = LW'(ENTRIES);
    end else begin
      lim = LW'(cap_r);
    end
  end

  assign full = LW'(count_r) >= lim;
  assign top  = full ? (count_r - CNT_W'(1)) : count_r;

  always_comb begin
    count_nxt = count_r;
    if (apply && !hit_any && (op_r == OP_PUT) && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell_ctl_t   ctl;
    logic [KEY_W-1:0] prev_key;
    logic [VAL_W-1:0] prev_val;
    logic             prev_valid;

    if (i == 0) begin : g_head
      assign prev_key   = key_r;
      assign prev_val   = head_val;
      assign prev_valid = 1'b1;
    end else begin : g_link
      assign prev_key   = cell_key[i-1];
      assign prev_val   = cell_val[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    assign ctl.capture = accept;
    assign ctl.shift   = apply && (hit_any ? !seen[i]
                                           : ((op_r == OP_PUT) && (CNT_W'(i) <= top)));

    lkvc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cmp_key    (in_tdata[31:0]),
      .prev_key   (prev_key),
      .prev_val   (prev_val),
      .prev_valid (prev_valid),
      .seen_in    (seen[i]),
      .key        (cell_key[i]),
      .val        (cell_val[i]),
      .valid      (cell_valid[i]),
      .match      (cell_match[i]),
      .seen_out   (seen[i+1])
    );
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r <= hit_any;
      out_val_r <= hit_any ? hit_val : MISS_VALUE;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_val_r;

  logic [ENTRIES-1:0] valid_expect;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_expect[i] = CNT_W'(i) < count_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above depth");

  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_match))
    else $error("key matched in more than one cell");

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid == valid_expect)
    else $error("valid cells do not form a prefix of the entry count");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    apply |=> count_r >= $past(count_r))
    else $error("entry count dropped");

  a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
    (apply && (op_r == OP_GET)) |=> out_valid_r)
    else $error("get finished without a result");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU key-value cache core: gets and puts stream
// in with random gaps, a lookup tracker mirrors the cache contents and the
// recency order, and every get result is compared with its predicted value.
// ---------------------------------------------------------------------------

typedef struct {
  logic        hit;
  logic [31:0] read_value;
} lookup_t;

class lookup_tracker;
  localparam int SLOTS = 16;

  logic [31:0]  slot_key  [SLOTS];
  logic [31:0]  slot_val  [SLOTS];
  bit           slot_used [SLOTS];
  int unsigned  slot_age  [SLOTS];
  int unsigned  used_count;
  logic [4:0]   capacity;
  lookup_t      pending_lookups[$];
  int           errors;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 0;
      slot_age[i]  = 0;
    end
    used_count = 0;
    capacity   = lkvc_pkg::CAP_RESET;
    errors     = 0;
  endfunction

  function void set_capacity(logic [4:0] c);
    capacity = c;
  endfunction

  function int pending();
    return pending_lookups.size();
  endfunction

  function void promote(int s);
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function int drop_oldest();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i] && (best < 0 || slot_age[i] > slot_age[best])) best = i;
    if (best >= 0) begin
      slot_used[best] = 0;
      if (used_count > 0) used_count--;
    end
    return best;
  endfunction

  function void note_access(logic op, logic [31:0] key, logic [31:0] value);
    int      s;
    int      lim;
    lookup_t res;
    s = -1;
    for (int i = 0; i < SLOTS; i++)
      if (s < 0 && slot_used[i] && slot_key[i] == key) s = i;
    if (op == lkvc_pkg::OP_GET) begin
      if (s >= 0) begin
        promote(s);
        res.hit        = 1'b1;
        res.read_value = slot_val[s];
      end else begin
        res.hit        = 1'b0;
        res.read_value = lkvc_pkg::MISS_VALUE;
      end
      pending_lookups.push_back(res);
      return;
    end
    if (s >= 0) begin
      slot_val[s] = value;
      promote(s);
      return;
    end
    lim = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
    if (used_count >= lim) begin
      s = drop_oldest();
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && !slot_used[i]) s = i;
    end
    if (s < 0) s = drop_oldest();
    if (s < 0) return;
    for (int i = 0; i < SLOTS; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_key[s]  = key;
    slot_val[s]  = value;
    slot_used[s] = 1;
    slot_age[s]  = 0;
    used_count++;
  endfunction

  function void check_lookup(logic hit, logic [31:0] read_value);
    lookup_t exp;
    if (pending_lookups.size() == 0) begin
      $error("unexpected transfer: hit %0b read_value %h", hit, read_value);
      errors++;
      return;
    end
    exp = pending_lookups.pop_front();
    if (hit !== exp.hit) begin
      $error("hit: expected %0b, actual %0b", exp.hit, hit);
      errors++;
    end
    if (read_value !== exp.read_value) begin
      $error("read_value: expected %h, actual %h", exp.read_value, read_value);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import lkvc_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 4;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  lookup_tracker tracker = new();
  bit            no_idle = 0;
  int            results_seen = 0;
  int            idle_cycles = 0;

  lru_key_value_cache_core #(.ENTRIES(16)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_access(input logic op, input logic [31:0] key,
                             input logic [31:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {value, key};
    do @(posedge clk); while (!in_tready);
    tracker.note_access(op, key, value);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [4:0] c);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_capacity(c);
  endtask

  initial begin
    int stall;
    bit held;
    held = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (!held && results_seen >= 80) begin
        held  = 1;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_lookup(out_tuser, out_tdata);
      results_seen++;
    end
  end

  initial begin
    logic [4:0]  caps [8];
    logic [31:0] key_pool[$];
    logic [31:0] key;
    logic        op;
    int          lim;

    caps = '{5'd16, 5'd1, 5'd4, 5'd31, 5'd2, 5'd0, 5'd8, 5'd16};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_access(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(OP_GET, 32'h1234_5678, 32'h0000_0000);
    send_access(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
    // shrink below the current fill level
    write_capacity(5'd1);
    send_access(OP_PUT, 32'h0000_0001, 32'h5A5A_5A5A);
    send_access(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_access(OP_GET, 32'h8000_0000, 32'h0000_0000);
    send_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
    write_capacity(5'd0);
    send_access(OP_PUT, 32'h0000_0002, 32'h0F0F_0F0F);
    send_access(OP_GET, 32'h0000_0001, 32'h0000_0000);
    send_access(OP_GET, 32'h0000_0002, 32'h0000_0000);
    write_capacity(5'd31);
    send_access(OP_PUT, 32'h0000_0003, 32'hF0F0_F0F0);
    send_access(OP_GET, 32'h0000_0002, 32'h0000_0000);
    send_access(OP_GET, 32'h0000_0003, 32'h0000_0000);

    for (int p = 0; p < 8; p++) begin
      write_capacity(p == 7 ? 5'($urandom_range(0, 31)) : caps[p]);
      lim = (tracker.capacity == 0) ? 1 : (tracker.capacity > 16) ? 16 : tracker.capacity;
      key_pool.delete();
      for (int i = 0; i < lim + $urandom_range(1, 6); i++) key_pool.push_back($urandom);
      no_idle = (p == 2);
      for (int n = 0; n < 50; n++) begin
        if (p == 3 && n == 25) drain_results();
        if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else key = $urandom;
        op = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
        send_access(op, key, $urandom);
      end
    end
    no_idle = 0;

    drain_results();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
